### rtl/cmfa_pkg.sv
// ----------------------------------------------------------------------------
// cmfa_pkg
// Shared types and constants of the cube map face addressing pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cmfa_pkg;

  // Face codes.
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // Configuration register map.
  localparam logic [1:0]  REG_FACE_SIZE_ADDR = 2'd0;
  localparam logic [12:0] FACE_SIZE_RESET    = 13'd256;
  localparam int          FACE_SIZE_MAX_DEF  = 4096;

  // Divider layout: quotient bits resolved per pipeline stage.
  localparam int QUO_BITS           = 15;
  localparam int DIV_BITS_PER_STAGE = 3;
  localparam int DIV_STAGES         = QUO_BITS / DIV_BITS_PER_STAGE;

  // One in Q2.14; also the offset that moves a coordinate into 0..2.
  localparam logic [15:0] COORD_ONE = 16'd16384;

  // Result of the major axis selection.
  typedef struct packed {
    logic [2:0]  face;
    logic        invalid;
    logic [15:0] den;
    logic [15:0] mag_u;
    logic        neg_u;
    logic [15:0] mag_v;
    logic        neg_v;
  } cmfa_sel_t;

  // Fields that ride alongside the divider and quantizer.
  typedef struct packed {
    logic [2:0] face;
    logic       invalid;
  } cmfa_side_t;

endpackage

`default_nettype wire

### rtl/cube_map_face_addressing_top.sv
// ----------------------------------------------------------------------------
// cube_map_face_addressing_top
// Maps a Q1.15 direction vector to a cube face, Q2.14 face coordinates and
// clamped pixel indices.
// ----------------------------------------------------------------------------
// Usage:
// A request (dir_x_i, dir_y_i, dir_z_i) is taken at every rising edge at which
// start is high and busy is low. busy is always low, so one request can be
// issued in every cycle with no gaps, and requests are fully independent.
// The result appears on the result ports for exactly one cycle, marked by
// result_valid_o. Results leave in request order, one per request.
// The pipeline consists of two stages of input capture and major
// axis selection, five stages of a restoring divider that resolves three
// quotient bits each, one stage for sign and offset, and two quantizer
// stages (multiply by the face size, then clamp).
// The receiver cannot stall, so nothing is ever held back inside the pipe.
// The APB port holds one register, face_size, at address 0. It is sampled
// continuously and should be written only while no request is in flight.
// Reset clears all pipeline valid bits, so no result strobe fires until new
// requests arrive, and sets face_size to 256.
// ----------------------------------------------------------------------------
`default_nettype none

module cube_map_face_addressing_top #(
  parameter int FACE_SIZE_MAX = cmfa_pkg::FACE_SIZE_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Request channel.
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  // Result channel.
  output logic               result_valid_o,
  output logic [2:0]         face_index_o,
  output logic signed [15:0] coord_u_o,
  output logic signed [15:0] coord_v_o,
  output logic [11:0]        pixel_col_o,
  output logic [11:0]        pixel_row_o,
  output logic               invalid_dir_o,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import cmfa_pkg::*;

  // Sideband delay covers the divider, the sign stage and the quantizer.
  localparam int SIDE_DEPTH = DIV_STAGES + 3;

  logic        accept;
  logic [12:0] face_size_q;
  logic [12:0] fs_sat;

  // The pipeline never stalls, so every request is taken on arrival.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration register.
  assign pready = 1'b1;
  assign prdata = {19'b0, face_size_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      face_size_q <= FACE_SIZE_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_FACE_SIZE_ADDR) begin
      face_size_q <= pwdata[12:0];
    end
  end

  // The face size in use is saturated to 1..FACE_SIZE_MAX.
  always_comb begin
    if (face_size_q == 13'd0) begin
      fs_sat = 13'd1;
    end else if (32'(face_size_q) > 32'(FACE_SIZE_MAX)) begin
      fs_sat = 13'(FACE_SIZE_MAX);
    end else begin
      fs_sat = face_size_q;
    end
  end

  // Major axis and face selection.
  logic      sel_valid;
  cmfa_sel_t sel;

  cmfa_face_sel u_face_sel (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .dir_x_i (dir_x_i),
    .dir_y_i (dir_y_i),
    .dir_z_i (dir_z_i),
    .valid_o (sel_valid),
    .sel_o   (sel)
  );

  // One divider lane per face coordinate.
  logic               du_valid, dv_valid;
  logic signed [15:0] du_coord, dv_coord;
  logic [15:0]        du_offset, dv_offset;

  cmfa_div_lane u_div_u (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sel_valid),
    .mag_i    (sel.mag_u),
    .den_i    (sel.den),
    .neg_i    (sel.neg_u),
    .zero_i   (sel.invalid),
    .valid_o  (du_valid),
    .coord_o  (du_coord),
    .offset_o (du_offset)
  );

  cmfa_div_lane u_div_v (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sel_valid),
    .mag_i    (sel.mag_v),
    .den_i    (sel.den),
    .neg_i    (sel.neg_v),
    .zero_i   (sel.invalid),
    .valid_o  (dv_valid),
    .coord_o  (dv_coord),
    .offset_o (dv_offset)
  );

  // Pixel quantizers; their last stage is the output register.
  logic qu_valid, qv_valid;

  cmfa_quant u_quant_u (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (du_valid),
    .offset_i (du_offset),
    .coord_i  (du_coord),
    .fs_i     (fs_sat),
    .valid_o  (qu_valid),
    .pixel_o  (pixel_col_o),
    .coord_o  (coord_u_o)
  );

  cmfa_quant u_quant_v (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv_valid),
    .offset_i (dv_offset),
    .coord_i  (dv_coord),
    .fs_i     (fs_sat),
    .valid_o  (qv_valid),
    .pixel_o  (pixel_row_o),
    .coord_o  (coord_v_o)
  );

  // Face and invalid flag follow the coordinates through a plain delay line.
  cmfa_side_t side_q [SIDE_DEPTH];

  always_ff @(posedge clk_i) begin
    side_q[0] <= '{face: sel.face, invalid: sel.invalid};
    for (int i = 1; i < SIDE_DEPTH; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // Both lanes run in lockstep, so either valid would do.
  assign result_valid_o = qu_valid && qv_valid;
  assign face_index_o   = side_q[SIDE_DEPTH-1].face;
  assign invalid_dir_o  = side_q[SIDE_DEPTH-1].invalid;

endmodule

`default_nettype wire

### rtl/cmfa_face_sel.sv
// ----------------------------------------------------------------------------
// cmfa_face_sel
// Input register and major axis / face selection stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfa_face_sel (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic signed [15:0] dir_x_i,
  input  logic signed [15:0] dir_y_i,
  input  logic signed [15:0] dir_z_i,
  output logic               valid_o,
  output cmfa_pkg::cmfa_sel_t sel_o
);
  import cmfa_pkg::*;

  logic               in_v_q;
  logic signed [15:0] x_q, y_q, z_q;
  logic [15:0]        ax, ay, az;
  logic               x_pos, y_pos, z_pos;
  cmfa_sel_t          sel_d, sel_q;
  logic               out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      in_v_q  <= valid_i;
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      x_q <= dir_x_i;
      y_q <= dir_y_i;
      z_q <= dir_z_i;
    end
    sel_q <= sel_d;
  end

  // Magnitudes fit 16 unsigned bits, the most negative input included.
  assign ax = x_q[15] ? 16'(-x_q) : 16'(x_q);
  assign ay = y_q[15] ? 16'(-y_q) : 16'(y_q);
  assign az = z_q[15] ? 16'(-z_q) : 16'(z_q);

  assign x_pos = !x_q[15] && (x_q != 16'sd0);
  assign y_pos = !y_q[15] && (y_q != 16'sd0);
  assign z_pos = !z_q[15] && (z_q != 16'sd0);

  // The sign flags tell whether the face numerator is negative.
  always_comb begin
    sel_d = '0;
    if (ax >= ay && ax >= az) begin
      sel_d.den   = ax;
      sel_d.mag_u = az;
      sel_d.mag_v = ay;
      sel_d.neg_v = y_pos;
      if (x_pos) begin
        sel_d.face  = FACE_POS_X;
        sel_d.neg_u = z_pos;
      end else begin
        sel_d.face  = FACE_NEG_X;
        sel_d.neg_u = z_q[15];
      end
    end else if (ay >= az) begin
      sel_d.den   = ay;
      sel_d.mag_u = ax;
      sel_d.mag_v = az;
      sel_d.neg_u = x_q[15];
      if (y_pos) begin
        sel_d.face  = FACE_POS_Y;
        sel_d.neg_v = z_q[15];
      end else begin
        sel_d.face  = FACE_NEG_Y;
        sel_d.neg_v = z_pos;
      end
    end else begin
      sel_d.den   = az;
      sel_d.mag_u = ax;
      sel_d.mag_v = ay;
      sel_d.neg_v = y_pos;
      if (z_pos) begin
        sel_d.face  = FACE_POS_Z;
        sel_d.neg_u = x_q[15];
      end else begin
        sel_d.face  = FACE_NEG_Z;
        sel_d.neg_u = x_pos;
      end
    end
    sel_d.invalid = (sel_d.den == 16'd0);
  end

  assign valid_o = out_v_q;
  assign sel_o   = sel_q;

endmodule

`default_nettype wire

### rtl/cmfa_div_lane.sv
// ----------------------------------------------------------------------------
// cmfa_div_lane
// Pipelined restoring divider giving one Q2.14 face coordinate.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfa_div_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [15:0]        mag_i,
  input  logic [15:0]        den_i,
  input  logic               neg_i,
  input  logic               zero_i,
  output logic               valid_o,
  output logic signed [15:0] coord_o,
  output logic [15:0]        offset_o
);
  import cmfa_pkg::*;

  localparam int LAST = DIV_STAGES - 1;

  // Dividend is mag * 2^14 plus half the divisor, for rounding half up.
  logic [29:0] num;
  assign num = {mag_i, 14'b0} + {15'b0, den_i[15:1]};

  logic [DIV_STAGES-1:0]               v_q;
  logic [DIV_STAGES-1:0][15:0]         r_q;
  logic [DIV_STAGES-1:0][15:0]         d_q;
  logic [DIV_STAGES-1:0][QUO_BITS-1:0] n_q;
  logic [DIV_STAGES-1:0][QUO_BITS-1:0] qt_q;
  logic [DIV_STAGES-1:0]               neg_q;
  logic [DIV_STAGES-1:0]               zero_q;

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic                v_in, neg_in, zero_in;
    logic [15:0]         r_in, d_in, r_d;
    logic [QUO_BITS-1:0] n_in, qt_in, n_d, qt_d;
    logic [16:0]         rr;

    if (s == 0) begin : g_first
      assign v_in    = valid_i;
      assign r_in    = {1'b0, num[29:15]};
      assign n_in    = num[14:0];
      assign qt_in   = '0;
      assign d_in    = den_i;
      assign neg_in  = neg_i;
      assign zero_in = zero_i;
    end else begin : g_next
      assign v_in    = v_q[s-1];
      assign r_in    = r_q[s-1];
      assign n_in    = n_q[s-1];
      assign qt_in   = qt_q[s-1];
      assign d_in    = d_q[s-1];
      assign neg_in  = neg_q[s-1];
      assign zero_in = zero_q[s-1];
    end

    // Each step brings down one dividend bit and resolves one quotient bit.
    always_comb begin
      r_d  = r_in;
      n_d  = n_in;
      qt_d = qt_in;
      rr   = '0;
      for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
        rr = {r_d, n_d[QUO_BITS-1]};
        if (rr >= {1'b0, d_in}) begin
          r_d  = 16'(rr - {1'b0, d_in});
          qt_d = {qt_d[QUO_BITS-2:0], 1'b1};
        end else begin
          r_d  = rr[15:0];
          qt_d = {qt_d[QUO_BITS-2:0], 1'b0};
        end
        n_d = {n_d[QUO_BITS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      r_q[s]    <= r_d;
      n_q[s]    <= n_d;
      qt_q[s]   <= qt_d;
      d_q[s]    <= d_in;
      neg_q[s]  <= neg_in;
      zero_q[s] <= zero_in;
    end
  end

  // Apply the sign and form coord + 1, which the quantizer scales.
  logic [15:0]        quo;
  logic signed [15:0] coord_d;
  logic [15:0]        offset_d;
  logic               out_v_q;
  logic signed [15:0] coord_q;
  logic [15:0]        offset_q;

  assign quo = {1'b0, qt_q[LAST]};

  always_comb begin
    if (zero_q[LAST]) begin
      coord_d  = '0;
      offset_d = COORD_ONE;
    end else if (neg_q[LAST]) begin
      coord_d  = -$signed(quo);
      offset_d = COORD_ONE - quo;
    end else begin
      coord_d  = $signed(quo);
      offset_d = COORD_ONE + quo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else begin
      out_v_q <= v_q[LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    coord_q  <= coord_d;
    offset_q <= offset_d;
  end

  assign valid_o  = out_v_q;
  assign coord_o  = coord_q;
  assign offset_o = offset_q;

endmodule

`default_nettype wire

### rtl/cmfa_quant.sv
// ----------------------------------------------------------------------------
// cmfa_quant
// Two-stage pixel quantizer: scale by the face size, then clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module cmfa_quant (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [15:0]        offset_i,
  input  logic signed [15:0] coord_i,
  input  logic [12:0]        fs_i,
  output logic               valid_o,
  output logic [11:0]        pixel_o,
  output logic signed [15:0] coord_o
);

  logic               a_v_q, b_v_q;
  logic [28:0]        prod_d, prod_q;
  logic signed [15:0] a_coord_q, b_coord_q;
  logic [13:0]        pix_raw;
  logic [12:0]        lim;
  logic [13:0]        pix;
  logic [11:0]        pixel_q;

  assign prod_d = 29'(offset_i) * 29'(fs_i);

  // Pixel is the product divided by 2^15, clamped to the last pixel.
  assign pix_raw = prod_q[28:15];
  assign lim     = fs_i - 13'd1;
  assign pix     = (pix_raw > {1'b0, lim}) ? {1'b0, lim} : pix_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q    <= prod_d;
    a_coord_q <= coord_i;
    pixel_q   <= pix[11:0];
    b_coord_q <= a_coord_q;
  end

  assign valid_o = b_v_q;
  assign pixel_o = pixel_q;
  assign coord_o = b_coord_q;

endmodule

`default_nettype wire

### dv/tb_cube_map_face_addressing_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cube_map_face_addressing_top
// Self-checking bench for the cube map face addressing pipeline. A table of
// directed directions runs first, followed by random directions in bursts
// under several face sizes. Each result is checked against a typed-in row
// or a local model of the face selection, Q2.14 division and pixel quantizer.
// ----------------------------------------------------------------------------

module tb_cube_map_face_addressing_top;
  import cmfa_pkg::*;

  localparam int FACE_SIZE_MAX   = FACE_SIZE_MAX_DEF;
  localparam int LATENCY         = 10;
  localparam int DRAIN_CYCLES    = 2 * LATENCY;
  localparam int STALL_LIMIT     = 500;
  localparam int NUM_DIRECTED    = 24;
  localparam int NUM_PHASES      = 10;
  localparam int ITEMS_PER_PHASE = 143;

  // One expected result, in the widths of the result ports.
  typedef struct packed {
    logic [2:0]         face;
    logic signed [15:0] u;
    logic signed [15:0] v;
    logic [11:0]        col;
    logic [11:0]        row;
    logic               invalid;
  } face_hit_t;

  // One directed row. When has_hit is set, the expected result is typed in
  // (valid for the reset face size of 256); otherwise the model supplies it.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               has_hit;
    face_hit_t          hit;
  } dir_row_t;

  // Clock and reset.
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #10 clk_i = ~clk_i;

  // Stimulus side of the block. Every input is known from time zero.
  logic               start   = 1'b0;
  logic signed [15:0] dir_x_i = '0;
  logic signed [15:0] dir_y_i = '0;
  logic signed [15:0] dir_z_i = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [1:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;

  logic               busy;
  logic               result_valid_o;
  logic [2:0]         face_index_o;
  logic signed [15:0] coord_u_o;
  logic signed [15:0] coord_v_o;
  logic [11:0]        pixel_col_o;
  logic [11:0]        pixel_row_o;
  logic               invalid_dir_o;
  logic [31:0]        prdata;
  logic               pready;

  cube_map_face_addressing_top #(
    .FACE_SIZE_MAX(FACE_SIZE_MAX)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .dir_x_i       (dir_x_i),
    .dir_y_i       (dir_y_i),
    .dir_z_i       (dir_z_i),
    .result_valid_o(result_valid_o),
    .face_index_o  (face_index_o),
    .coord_u_o     (coord_u_o),
    .coord_v_o     (coord_v_o),
    .pixel_col_o   (pixel_col_o),
    .pixel_row_o   (pixel_row_o),
    .invalid_dir_o (invalid_dir_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // The bench's own copy of the face size register, and the results that
  // accepted requests still owe, oldest first.
  logic [12:0] face_size_cfg = FACE_SIZE_RESET;
  face_hit_t   pending_hits[$];
  int          errors = 0;
  int          quiet_cycles = 0;

  // Directed directions: axis extremes, the most negative component, every
  // face, the tie rules, the zero vector, and rounding corners.
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{16'sd0, 16'sd0, 16'sd0, 1'b1,
      '{FACE_NEG_X, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b1}},
    '{16'sd32767, 16'sd0, 16'sd0, 1'b1,
      '{FACE_POS_X, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sh8000, 16'sd0, 16'sd0, 1'b1,
      '{FACE_NEG_X, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd0, 16'sd32767, 16'sd0, 1'b1,
      '{FACE_POS_Y, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd0, 16'sh8000, 16'sd0, 1'b1,
      '{FACE_NEG_Y, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd0, 16'sd0, 16'sd32767, 1'b1,
      '{FACE_POS_Z, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd0, 16'sd0, 16'sh8000, 1'b1,
      '{FACE_NEG_Z, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd32767, 16'sd32767, 16'sd32767, 1'b1,
      '{FACE_POS_X, -16'sd16384, -16'sd16384, 12'd0, 12'd0, 1'b0}},
    '{16'sh8000, 16'sh8000, 16'sh8000, 1'b1,
      '{FACE_NEG_X, -16'sd16384, 16'sd16384, 12'd0, 12'd255, 1'b0}},
    '{16'sd32767, -16'sd32767, 16'sd0, 1'b1,
      '{FACE_POS_X, 16'sd0, 16'sd16384, 12'd128, 12'd255, 1'b0}},
    '{16'sd0, 16'sd32767, -16'sd32767, 1'b1,
      '{FACE_POS_Y, 16'sd0, -16'sd16384, 12'd128, 12'd0, 1'b0}},
    '{16'sd0, -16'sd32767, 16'sd32767, 1'b1,
      '{FACE_NEG_Y, 16'sd0, -16'sd16384, 12'd128, 12'd0, 1'b0}},
    '{16'sd1, 16'sd1, 16'sd1, 1'b1,
      '{FACE_POS_X, -16'sd16384, -16'sd16384, 12'd0, 12'd0, 1'b0}},
    '{-16'sd1, 16'sd0, 16'sd0, 1'b1,
      '{FACE_NEG_X, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd0, 16'sd0, -16'sd1, 1'b1,
      '{FACE_NEG_Z, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd1, 16'sd0, 16'sd0, 1'b1,
      '{FACE_POS_X, 16'sd0, 16'sd0, 12'd128, 12'd128, 1'b0}},
    '{16'sd3, 16'sd1, 16'sd0, 1'b0, '0},
    '{16'sd32767, 16'sh8000, 16'sd0, 1'b0, '0},
    '{16'sh8000, 16'sd16384, -16'sd16384, 1'b0, '0},
    '{16'sd12345, -16'sd6789, 16'sd2222, 1'b0, '0},
    '{16'sd2, -16'sd1, 16'sd1, 1'b0, '0},
    '{16'sh8000, 16'sd1, -16'sd1, 1'b0, '0},
    '{16'sd100, -16'sd200, 16'sd199, 1'b0, '0},
    '{-16'sd5, 16'sd3, -16'sd5, 1'b0, '0}
  };

  // num * 2^14 / den, rounded to nearest with ties away from zero.
  function automatic int round_q14(int num, int den);
    longint mag_num;
    longint quo;
    mag_num = (num < 0) ? -longint'(num) : longint'(num);
    quo = ((mag_num <<< 14) + (den >>> 1)) / den;
    return (num < 0) ? -int'(quo) : int'(quo);
  endfunction

  // Pixel index of a Q2.14 coordinate on a face of fs pixels, clamped.
  function automatic logic [11:0] pixel_of(int coord, int fs);
    longint pix;
    pix = (longint'(coord + 16384) * fs) >>> 15;
    if (pix > fs - 1) begin
      pix = fs - 1;
    end
    return 12'(pix);
  endfunction

  // Expected result of one direction under a given face size register.
  function automatic face_hit_t map_direction(logic signed [15:0] x,
                                              logic signed [15:0] y,
                                              logic signed [15:0] z,
                                              logic [12:0] size_reg);
    face_hit_t hit;
    int ax, ay, az;
    int nu, nv, den, fs, u, v;
    ax = (x < 0) ? -int'(x) : int'(x);
    ay = (y < 0) ? -int'(y) : int'(y);
    az = (z < 0) ? -int'(z) : int'(z);
    // A face size of zero behaves as one; large values saturate.
    fs = int'(size_reg);
    if (fs < 1) begin
      fs = 1;
    end
    if (fs > FACE_SIZE_MAX) begin
      fs = FACE_SIZE_MAX;
    end
    // Major axis, with x winning ties over y and y over z.
    if (ax >= ay && ax >= az) begin
      den = ax;
      hit.face = (x > 0) ? FACE_POS_X : FACE_NEG_X;
      nu = (x > 0) ? -int'(z) : int'(z);
      nv = -int'(y);
    end else if (ay >= az) begin
      den = ay;
      hit.face = (y > 0) ? FACE_POS_Y : FACE_NEG_Y;
      nu = int'(x);
      nv = (y > 0) ? int'(z) : -int'(z);
    end else begin
      den = az;
      hit.face = (z > 0) ? FACE_POS_Z : FACE_NEG_Z;
      nu = (z > 0) ? int'(x) : -int'(x);
      nv = -int'(y);
    end
    // The zero vector lands on the -X face with both coordinates at zero.
    hit.invalid = (den == 0);
    u = 0;
    v = 0;
    if (!hit.invalid) begin
      u = round_q14(nu, den);
      v = round_q14(nv, den);
    end
    hit.u   = 16'(u);
    hit.v   = 16'(v);
    hit.col = pixel_of(u, fs);
    hit.row = pixel_of(v, fs);
    return hit;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // Result checker. The receiver cannot stall, so every strobe is a result
  // accepted at this edge; it must match the oldest owed result.
  always @(posedge clk_i) begin : check_results
    face_hit_t want;
    if (result_valid_o) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: result with no request pending, face %0d u %0d v %0d",
                 $time, face_index_o, coord_u_o, coord_v_o);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        check_field("face_index", want.face, face_index_o);
        check_field("coord_u", int'(want.u), int'(coord_u_o));
        check_field("coord_v", int'(want.v), int'(coord_v_o));
        check_field("pixel_col", want.col, pixel_col_o);
        check_field("pixel_row", want.row, pixel_row_o);
        check_field("invalid_dir", want.invalid, invalid_dir_o);
      end
    end
  end

  // Watchdog: cycles in which neither a request nor a result moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
    end
    $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Present one request and hold it until the block takes it. The caller is
  // always at a rising edge, so start stays high across back-to-back requests.
  task automatic issue_request(input logic signed [15:0] x,
                               input logic signed [15:0] y,
                               input logic signed [15:0] z,
                               input bit has_hit,
                               input face_hit_t typed_hit);
    start   <= 1'b1;
    dir_x_i <= x;
    dir_y_i <= y;
    dir_z_i <= z;
    do begin
      @(posedge clk_i);
    end while (busy);
    pending_hits.insert(pending_hits.size(),
                        has_hit ? typed_hit : map_direction(x, y, z, face_size_cfg));
  endtask

  // Drop start and put junk on the direction ports; n sets how long this lasts.
  task automatic go_idle(input int n);
    start   <= 1'b0;
    dir_x_i <= 16'($urandom());
    dir_y_i <= 16'($urandom());
    dir_z_i <= 16'($urandom());
    repeat (n) @(posedge clk_i);
  endtask

  // Wait until every owed result has arrived, then let the pipe settle.
  task automatic wait_drained();
    while (pending_hits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // One APB transfer: setup phase, then access phase until pready.
  task automatic apb_access(input bit wr, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= REG_FACE_SIZE_ADDR;
    pwdata  <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
  endtask

  // Read the face size register back and compare it with the bench copy.
  task automatic read_face_size();
    logic [31:0] rdata;
    apb_access(1'b0, 32'($urandom()), rdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rdata != 32'(face_size_cfg)) begin
      $display("%0t: face_size readback mismatch, expected %0d, actual %0d",
               $time, face_size_cfg, rdata);
      errors++;
    end
  endtask

  // Main stimulus.
  initial begin : stimulus
    logic [31:0]        wdata;
    logic [31:0]        rdata;
    logic signed [15:0] cx, cy, cz;
    int                 comp [3];
    int                 pick, axis, mag, minor, tie_mask;
    int                 burst_left;
    logic [12:0]        size_val;

    // Hold reset low, then release it on a rising edge.
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // The register must come out of reset at its documented value.
    read_face_size();
    @(posedge clk_i);

    // Directed table, back to back, at the reset face size.
    for (int r = 0; r < NUM_DIRECTED; r++) begin
      issue_request(directed_rows[r].x, directed_rows[r].y, directed_rows[r].z,
                    directed_rows[r].has_hit, directed_rows[r].hit);
    end
    go_idle(1);

    burst_left = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // Face sizes: the smallest, zero (acts as one), the largest, beyond the
      // largest (all register bits set), 2, largest - 1, 256, 3, then random.
      case (ph)
        0:       size_val = 13'd1;
        1:       size_val = 13'd0;
        2:       size_val = 13'(FACE_SIZE_MAX);
        3:       size_val = 13'h1FFF;
        4:       size_val = 13'd2;
        5:       size_val = 13'(FACE_SIZE_MAX - 1);
        6:       size_val = 13'd256;
        7:       size_val = 13'd3;
        8:       size_val = 13'($urandom_range(1, FACE_SIZE_MAX));
        default: size_val = 13'($urandom_range(0, 8191));
      endcase

      // The register is only touched with the pipe empty.
      wait_drained();
      wdata = $urandom();
      wdata[12:0] = size_val;
      apb_access(1'b1, wdata, rdata);
      face_size_cfg = size_val;
      read_face_size();
      @(posedge clk_i);

      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Sender pressure: hold off until the pipe has fully drained.
        if (i == ITEMS_PER_PHASE / 2 && (ph == 2 || $urandom_range(0, 3) == 0)) begin
          go_idle(1);
          while (pending_hits.size() != 0) begin
            @(posedge clk_i);
          end
        end

        // Bursts of random length; now and then a long one with no gaps.
        if (burst_left == 0) begin
          go_idle(($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8));
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                   : $urandom_range(1, 40);
        end
        burst_left--;

        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          // Any bit pattern, the most negative value included.
          for (int k = 0; k < 3; k++) comp[k] = int'($signed(16'($urandom())));
        end else if (pick < 45) begin
          // One dominant axis with minors up to its magnitude.
          axis = $urandom_range(0, 2);
          mag  = $urandom_range(1, 32768);
          for (int k = 0; k < 3; k++) begin
            minor = (k == axis) ? mag : $urandom_range(0, mag);
            comp[k] = $urandom_range(0, 1) ? -minor : minor;
          end
        end else if (pick < 60) begin
          // Equal magnitudes on two or three axes to exercise the tie rules.
          mag = ($urandom_range(0, 9) == 0) ? 32768 : $urandom_range(1, 32767);
          tie_mask = $urandom_range(0, 3);
          for (int k = 0; k < 3; k++) begin
            if (tie_mask == 3 || tie_mask != k) begin
              minor = mag;
            end else begin
              minor = $urandom_range(0, mag - 1);
            end
            comp[k] = $urandom_range(0, 1) ? -minor : minor;
          end
        end else if (pick < 75) begin
          // Tiny vectors, where rounding of the quotient matters most.
          for (int k = 0; k < 3; k++) comp[k] = $urandom_range(0, 6) - 3;
        end else if (pick < 80) begin
          // The zero vector, or one lone unit component.
          for (int k = 0; k < 3; k++) comp[k] = 0;
          if ($urandom_range(0, 1)) begin
            comp[$urandom_range(0, 2)] = $urandom_range(0, 1) ? -1 : 1;
          end
        end else if (pick < 90) begin
          // Component extremes in random combinations.
          for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 5))
              0:       comp[k] = -32768;
              1:       comp[k] = -32767;
              2:       comp[k] = -1;
              3:       comp[k] = 0;
              4:       comp[k] = 1;
              default: comp[k] = 32767;
            endcase
          end
        end else begin
          // The most negative value as major axis with random minors.
          for (int k = 0; k < 3; k++) comp[k] = int'($signed(16'($urandom())));
          comp[$urandom_range(0, 2)] = -32768;
        end

        // +32768 does not fit; its magnitude is kept by -32768.
        for (int k = 0; k < 3; k++) begin
          if (comp[k] > 32767) comp[k] = -32768;
        end
        cx = 16'(comp[0]);
        cy = 16'(comp[1]);
        cz = 16'(comp[2]);
        issue_request(cx, cy, cz, 1'b0, '0);
      end
      go_idle(1);
    end

    // Drain the pipe, then wait DRAIN_CYCLES longer to catch stray strobes.
    while (pending_hits.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### cube_map_face_addressing_top.f
rtl/cmfa_pkg.sv
rtl/cmfa_face_sel.sv
rtl/cmfa_div_lane.sv
rtl/cmfa_quant.sv
rtl/cube_map_face_addressing_top.sv
dv/tb_cube_map_face_addressing_top.sv
